// ===== hdl/kmat_pkg.sv =====
`default_nettype none
package kmat_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned Window = 16;
  localparam int unsigned EntW = $clog2(Entries);
  localparam int unsigned SlotW = $clog2(Window);
  localparam int unsigned CntW = $clog2(Window + 1);
  localparam int unsigned SampW = 24;
  localparam int unsigned TotW = SampW + SlotW;
  localparam int unsigned KeyW = 32;
  localparam int unsigned AvgW = 32;
  localparam int unsigned WinAddrW = EntW + SlotW;
  localparam int unsigned DivCntW = $clog2(AvgW + 1);

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_EOF    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             cmd;
    logic [KeyW-1:0]  key;
    logic [SampW-1:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic [AvgW-1:0] average;
    logic            new_key;
    logic            table_full;
    logic            frame_changed;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FREE,
    ST_RD,
    ST_RDWAIT,
    ST_UPDATE,
    ST_DIV,
    ST_EOF,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/kmat_ram.sv =====
`default_nettype none
module kmat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/kmat_div.sv =====
`default_nettype none
module kmat_div
  import kmat_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [TotW-1:0]       total,
  input  wire logic [CntW-1:0]       count,
  output logic                       done,
  output logic      [AvgW-1:0]       quot
);

  // Restoring division of (total << 8) by count, one quotient bit per cycle.
  // The dividend shifts out of quot_r as quotient bits shift in.
  // The quotient always fits in AvgW bits, so the dividend bits above AvgW are
  // smaller than count and start out as the partial remainder.
  logic [AvgW-1:0]    quot_r, quot_nxt;
  logic [CntW:0]      rem_r, rem_nxt;
  logic [CntW-1:0]    den_r, den_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic [CntW:0]      trial;
  logic [CntW+1:0]    diff;
  logic [TotW+7:0]    dividend;

  assign dividend = {total, 8'd0};

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[CntW-1:0], quot_r[AvgW-1]};
    diff     = {1'b0, trial} - {2'b00, den_r};
    if (start) begin
      quot_nxt = dividend[AvgW-1:0];
      rem_nxt  = (CntW + 1)'(dividend[TotW+7:AvgW]);
      den_nxt  = count;
      cnt_nxt  = DivCntW'(AvgW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[CntW+1]) begin
        rem_nxt  = diff[CntW:0];
        quot_nxt = {quot_r[AvgW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial;
        quot_nxt = {quot_r[AvgW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DivCntW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign done = busy_r && (cnt_r == DivCntW'(1));
  assign quot = quot_nxt;

endmodule
`default_nettype wire

// ===== hdl/keyed_moving_average_table.sv =====
// Channel  | Direction | Payload      | Handshake
// in_      | input     | in_item_t    | in_valid / in_stall
// out_     | output    | out_item_t   | out_valid / out_stall
//
// A sample of a known key runs a key search over one entry per cycle, a window
// memory read, then a 32-step serial divider.
// A new key or a full table skips the divider.
// End of frame sweeps the entry flags one per cycle.
// Synchronous active-low reset clears all flags, totals and counts at once.
// in_stall is high from acceptance until the result transaction is taken.
`default_nettype none
module keyed_moving_average_table (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire kmat_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output kmat_pkg::out_item_t      out_data
);
  import kmat_pkg::*;

  state_t state_r, state_nxt;
  logic [Entries-1:0] valid_r, valid_nxt, seen_r, seen_nxt;
  logic [KeyW-1:0]    keys_r [Entries];
  logic [TotW-1:0]    total_r [Entries];
  logic [CntW-1:0]    fill_r [Entries];
  logic [SlotW-1:0]   slot_r [Entries];
  logic               changed_r, changed_nxt;
  in_item_t           item_r, item_nxt;
  out_item_t          res_r, res_nxt;
  logic [EntW:0]      idx_r, idx_nxt;
  logic [EntW-1:0]    ent;
  logic [SampW-1:0]   old_samp;
  logic               wr_en;
  logic [WinAddrW-1:0] waddr, raddr;
  logic               tab_we;
  logic [TotW-1:0]    tab_total;
  logic [CntW-1:0]    tab_fill;
  logic [SlotW-1:0]   tab_slot;
  logic               key_we;
  logic               div_start, div_done;
  logic [AvgW-1:0]    div_q;

  assign ent = idx_r[EntW-1:0];
  assign raddr = {ent, slot_r[ent]};

  kmat_ram #(.Width(SampW), .Depth(Entries * Window)) u_win (
    .clk(clk), .we(wr_en), .waddr(waddr), .wdata(item_r.time_us),
    .raddr(raddr), .rdata(old_samp)
  );

  kmat_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .total(tab_total),
    .count(tab_fill), .done(div_done), .quot(div_q)
  );

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    seen_nxt    = seen_r;
    changed_nxt = changed_r;
    item_nxt    = item_r;
    res_nxt     = res_r;
    idx_nxt     = idx_r;
    wr_en       = 1'b0;
    waddr       = {ent, slot_r[ent]};
    tab_we      = 1'b0;
    tab_total   = total_r[ent];
    tab_fill    = fill_r[ent];
    tab_slot    = slot_r[ent];
    key_we      = 1'b0;
    div_start   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          idx_nxt  = '0;
          res_nxt  = '0;
          state_nxt = (in_data.cmd == CMD_EOF) ? ST_EOF : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (valid_r[ent] && keys_r[ent] == item_r.key) begin
          state_nxt = ST_RD;
        end else if (idx_r == (EntW + 1)'(Entries - 1)) begin
          idx_nxt = '0;
          state_nxt = ST_FREE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FREE: begin
        if (!valid_r[ent]) begin
          valid_nxt[ent] = 1'b1;
          seen_nxt[ent]  = 1'b1;
          key_we         = 1'b1;
          wr_en          = 1'b1;
          waddr          = {ent, {SlotW{1'b0}}};
          tab_we         = 1'b1;
          tab_total      = TotW'(item_r.time_us);
          tab_fill       = CntW'(1);
          tab_slot       = SlotW'(1);
          changed_nxt    = 1'b1;
          res_nxt.average = {item_r.time_us, 8'd0};
          res_nxt.new_key = 1'b1;
          state_nxt = ST_OUT;
        end else if (idx_r == (EntW + 1)'(Entries - 1)) begin
          res_nxt.average    = {item_r.time_us, 8'd0};
          res_nxt.table_full = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RD: state_nxt = ST_RDWAIT;
      ST_RDWAIT: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        seen_nxt[ent] = 1'b1;
        wr_en  = 1'b1;
        tab_we = 1'b1;
        tab_slot = slot_r[ent] + 1'b1;
        if (fill_r[ent] >= CntW'(Window)) begin
          tab_total = total_r[ent] - TotW'(old_samp) + TotW'(item_r.time_us);
        end else begin
          tab_total = total_r[ent] + TotW'(item_r.time_us);
          tab_fill  = fill_r[ent] + 1'b1;
        end
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt.average = div_q;
          state_nxt = ST_OUT;
        end
      end
      ST_EOF: begin
        if (valid_r[ent] && !seen_r[ent]) begin
          valid_nxt[ent] = 1'b0;
          changed_nxt = 1'b1;
        end
        seen_nxt[ent] = 1'b0;
        if (idx_r == (EntW + 1)'(Entries - 1)) begin
          res_nxt.frame_changed = changed_nxt;
          changed_nxt = 1'b0;
          state_nxt = ST_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      seen_r    <= '0;
      changed_r <= 1'b0;
      idx_r     <= '0;
      for (int i = 0; i < Entries; i++) begin
        total_r[i] <= '0;
        fill_r[i]  <= '0;
        slot_r[i]  <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      seen_r    <= seen_nxt;
      changed_r <= changed_nxt;
      idx_r     <= idx_nxt;
      if (tab_we) begin
        total_r[ent] <= tab_total;
        fill_r[ent]  <= tab_fill;
        slot_r[ent]  <= tab_slot;
      end
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
    if (key_we) begin
      keys_r[ent] <= item_r.key;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = res_r;

endmodule
`default_nettype wire
